// ===== design/encoder_speed_pid_macros.svh =====
// Assertion helpers used by the speed loop RTL.
// All checks sample on the rising clock edge and are off while reset is high.
`ifndef ENCODER_SPEED_PID_MACROS_SVH
`define ENCODER_SPEED_PID_MACROS_SVH

// Same-cycle implication.
`define ESP_ASSERT_IMPLIES(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define ESP_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== design/esp_pkg.sv =====
`default_nettype none

package esp_pkg;

   // field and datapath widths
   localparam int COUNT_W    = 32;
   localparam int SPEED_W    = 16;
   localparam int ERR_W      = SPEED_W + 1;
   localparam int DERR_W     = ERR_W + 1;
   localparam int SUM_W      = 48;
   localparam int GAIN_W     = 16;
   localparam int T_W        = GAIN_W + DERR_W;
   localparam int Q_W        = ERR_W + GAIN_W + 1;
   localparam int ACC_W      = 64;
   localparam int DRIVE_W    = 54;
   localparam int CMD_W      = 47;
   localparam int MUL_CNT_W  = $clog2(GAIN_W);

   // fixed point
   localparam int FRAC_SHIFT  = 8;
   localparam int I_SHIFT     = 16;
   localparam int DRIVE_LIMIT = 255;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PERIOD  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_RATE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_SPEED = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSED     = 3'd6;

   localparam logic [CSR_DATA_W-1:0] TICK_PERIOD_RESET = 16'd655;
   localparam logic [CSR_DATA_W-1:0] TICK_RATE_RESET   = 16'd100;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_T,
      ST_MUL_D,
      ST_MUL_Q,
      ST_FINISH
   } state_type;

   // multiplier control and status
   typedef struct packed {
      logic start;
      logic b_signed;
   } mul_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

`default_nettype wire

// ===== design/encoder_speed_pid.sv =====
// Speed loop for one wheel. Each request carries the raw encoder count and an open-loop
// flag and yields one response: the counts-per-tick speed and, in closed loop, the PID
// drive (integer part, sign corrected, saturated) with a flag set when |drive| exceeds
// 255; the integral is only updated while it does not and is cleared in open loop. All
// products go through one shared shift-add multiplier that retires one gain bit per cycle;
// an open-loop request does not use it. A new request is taken as soon as the previous
// response sits in the output register, even if it is not yet taken. Configuration is
// written through csr_we / csr_index / csr_wdata; the user must write it only while the
// block is idle, and the block itself does not enforce this.
`default_nettype none
`include "encoder_speed_pid_macros.svh"

module encoder_speed_pid
   import esp_pkg::*;
(
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   // request: tdata = encoder_count[31:0]; tuser = open_loop[0]
   input  wire  logic                   req_tvalid,
   output logic                         req_tready,
   input  wire  logic [31:0]            req_tdata,
   input  wire  logic [0:0]             req_tuser,
   // response: tdata = measured_speed[15:0], drive_value[31:16];
   //           tuser = drive_valid[0], output_maxed[1]
   output logic                         rsp_tvalid,
   input  wire  logic                   rsp_tready,
   output logic [31:0]                  rsp_tdata,
   output logic [1:0]                   rsp_tuser,
   // configuration writes
   input  wire  logic                   csr_we,
   input  wire  logic [CSR_INDEX_W-1:0] csr_index,
   input  wire  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic signed [DRIVE_W-1:0] LIMIT_Q   = DRIVE_W'(DRIVE_LIMIT * 256);
   localparam logic signed [DRIVE_W-1:0] ROUND_ADJ = DRIVE_W'((1 << FRAC_SHIFT) - 1);
   localparam logic signed [COUNT_W-1:0] SPEED_HI  = COUNT_W'(32767);
   localparam logic signed [COUNT_W-1:0] SPEED_LO  = -COUNT_W'(32768);
   localparam logic signed [CMD_W-1:0]   CMD_HI    = CMD_W'(32767);
   localparam logic signed [CMD_W-1:0]   CMD_LO    = -CMD_W'(32768);

   // configuration registers
   logic signed [GAIN_W-1:0]   gain_p_ff, gain_i_ff, gain_d_ff;
   logic [CSR_DATA_W-1:0]      tick_period_ff, tick_rate_ff;
   logic signed [SPEED_W-1:0]  target_ff;
   logic                       reversed_ff;

   // loop state
   logic [COUNT_W-1:0]         last_count_ff, last_count_in;
   logic signed [ERR_W-1:0]    last_error_ff, last_error_in;
   logic signed [SUM_W-1:0]    error_sum_ff, error_sum_in;

   // per-request working registers
   state_type                  state_ff, state_in;
   logic signed [SPEED_W-1:0]  speed_ff, speed_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic                       open_ff, open_in;
   logic signed [DRIVE_W-1:0]  drive_ff, drive_in;
   logic signed [T_W-1:0]      t_ff, t_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [31:0]                rsp_data_ff, rsp_data_in;
   logic [1:0]                 rsp_user_ff, rsp_user_in;

   // multiplier
   mul_ctrl_type               mul_ctrl;
   mul_stat_type               mul_stat;
   logic signed [ACC_W-1:0]    mul_a;
   logic [GAIN_W-1:0]          mul_b;
   logic signed [ACC_W-1:0]    mul_product;

   // datapath helpers
   logic signed [COUNT_W-1:0]  diff;
   logic signed [SPEED_W-1:0]  speed_sat;
   logic signed [DERR_W-1:0]   derr;
   logic signed [Q_W-1:0]      q_term;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [SUM_W-1:0]    sum_sat;
   logic signed [DRIVE_W-1:0]  drive_round;
   logic signed [CMD_W-1:0]    cmd_wide;
   logic signed [SPEED_W-1:0]  cmd_sat;
   logic                       maxed;
   logic                       accept;
   logic                       load;

   function automatic logic drive_over(input logic signed [DRIVE_W-1:0] d);
      drive_over = (d > LIMIT_Q) || (d < -LIMIT_Q);
   endfunction

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         tick_period_ff <= TICK_PERIOD_RESET;
         tick_rate_ff   <= TICK_RATE_RESET;
         target_ff      <= '0;
         reversed_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN_P:       gain_p_ff      <= csr_wdata;
            CSR_GAIN_I:       gain_i_ff      <= csr_wdata;
            CSR_GAIN_D:       gain_d_ff      <= csr_wdata;
            CSR_TICK_PERIOD:  tick_period_ff <= csr_wdata;
            CSR_TICK_RATE:    tick_rate_ff   <= csr_wdata;
            CSR_TARGET_SPEED: target_ff      <= csr_wdata;
            CSR_REVERSED:     reversed_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // speed: wrapped count difference, saturated
   always_comb begin
      diff = req_tdata - last_count_ff;
      if (diff > SPEED_HI) begin
         speed_sat = SPEED_W'(SPEED_HI);
      end else if (diff < SPEED_LO) begin
         speed_sat = SPEED_W'(SPEED_LO);
      end else begin
         speed_sat = SPEED_W'(diff);
      end
   end

   // integral step, saturated to the integral range
   always_comb begin
      q_term   = Q_W'(mul_product);
      sum_wide = (SUM_W + 1)'(error_sum_ff) + (SUM_W + 1)'(q_term);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                   : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         sum_sat = SUM_W'(sum_wide);
      end
   end

   // drive integer part: truncate toward zero, optional negate, saturate
   always_comb begin
      maxed       = drive_over(drive_ff);
      drive_round = drive_ff + (drive_ff[DRIVE_W-1] ? ROUND_ADJ : '0);
      cmd_wide    = CMD_W'(drive_round >>> FRAC_SHIFT);
      if (reversed_ff) begin
         cmd_wide = -cmd_wide;
      end
      if (cmd_wide > CMD_HI) begin
         cmd_sat = SPEED_W'(CMD_HI);
      end else if (cmd_wide < CMD_LO) begin
         cmd_sat = SPEED_W'(CMD_LO);
      end else begin
         cmd_sat = SPEED_W'(cmd_wide);
      end
   end

   assign derr = DERR_W'(err_ff) - DERR_W'(last_error_ff);

   // multiplier operand select and start
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_ctrl.b_signed = 1'b1;
      mul_ctrl.start    = (state_ff != ST_IDLE) && (state_ff != ST_FINISH) &&
                          !mul_stat.busy && !mul_stat.done;
      case (state_ff)
         ST_MUL_P: begin
            mul_a = ACC_W'(err_ff);
            mul_b = gain_p_ff;
         end
         ST_MUL_I: begin
            mul_a = ACC_W'(error_sum_ff);
            mul_b = gain_i_ff;
         end
         ST_MUL_T: begin
            mul_a = ACC_W'(derr);
            mul_b = gain_d_ff;
         end
         ST_MUL_D: begin
            mul_a = ACC_W'(t_ff);
            mul_b = tick_rate_ff;
            mul_ctrl.b_signed = 1'b0;
         end
         ST_MUL_Q: begin
            mul_a = ACC_W'(err_ff);
            mul_b = tick_period_ff;
            mul_ctrl.b_signed = 1'b0;
         end
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;
   assign load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      last_count_in = last_count_ff;
      last_error_in = last_error_ff;
      error_sum_in  = error_sum_ff;
      speed_in      = speed_ff;
      err_in        = err_ff;
      open_in       = open_ff;
      drive_in      = drive_ff;
      t_in          = t_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      req_tready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               last_count_in = req_tdata;
               speed_in      = speed_sat;
               err_in        = ERR_W'(target_ff) - ERR_W'(speed_sat);
               open_in       = req_tuser[0];
               if (req_tuser[0]) begin
                  error_sum_in = '0;
                  state_in     = ST_FINISH;
               end else begin
                  state_in = ST_MUL_P;
               end
            end
         end
         ST_MUL_P: begin
            if (mul_stat.done) begin
               drive_in = DRIVE_W'(mul_product);
               state_in = ST_MUL_I;
            end
         end
         ST_MUL_I: begin
            if (mul_stat.done) begin
               drive_in = drive_ff + DRIVE_W'(mul_product >>> I_SHIFT);
               state_in = ST_MUL_T;
            end
         end
         ST_MUL_T: begin
            if (mul_stat.done) begin
               t_in     = T_W'(mul_product);
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            if (mul_stat.done) begin
               drive_in = drive_ff + DRIVE_W'(mul_product);
               state_in = drive_over(drive_in) ? ST_FINISH : ST_MUL_Q;
            end
         end
         ST_MUL_Q: begin
            if (mul_stat.done) begin
               error_sum_in = sum_sat;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               if (open_ff) begin
                  rsp_data_in = {16'd0, speed_ff};
                  rsp_user_in = 2'b00;
               end else begin
                  rsp_data_in   = {cmd_sat, speed_ff};
                  rsp_user_in   = {maxed, 1'b1};
                  last_error_in = err_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_count_ff <= '0;
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_count_ff <= last_count_in;
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      speed_ff    <= speed_in;
      err_ff      <= err_in;
      open_ff     <= open_in;
      drive_ff    <= drive_in;
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   esp_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mul_ctrl),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .stat    (mul_stat),
      .product (mul_product)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `ESP_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != ST_IDLE, "request accepted but sequencer stayed idle")
   `ESP_ASSERT_IMPLIES(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH), "response appeared outside the finish step")
   `ESP_ASSERT_IMPLIES(a_open_no_drive, rsp_valid_ff && !rsp_user_ff[0], rsp_data_ff[31:16] == 16'd0 && !rsp_user_ff[1], "open-loop response carries a drive")

endmodule

`default_nettype wire

// ===== design/esp_serial_mul.sv =====
`default_nettype none

// Shift-add multiplier: one multiplier bit per cycle, LSB first.
module esp_serial_mul
   import esp_pkg::*;
(
   input  wire  logic                     clock,
   input  wire  logic                     reset,
   input  wire  mul_ctrl_type             ctrl,
   input  wire  logic signed [ACC_W-1:0]  mul_a,
   input  wire  logic [GAIN_W-1:0]        mul_b,
   output mul_stat_type                   stat,
   output logic signed [ACC_W-1:0]        product
);

   logic signed [ACC_W-1:0]  mcand_ff, mcand_in;
   logic [GAIN_W-1:0]        mplier_ff, mplier_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [MUL_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                     bsigned_ff, bsigned_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   // one partial product per cycle; the top bit of a signed multiplier weighs negative
   always_comb begin
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      bsigned_in = bsigned_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (ctrl.start && !busy_ff) begin
         mcand_in   = mul_a;
         mplier_in  = mul_b;
         acc_in     = '0;
         cnt_in     = MUL_CNT_W'(GAIN_W - 1);
         bsigned_in = ctrl.b_signed;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            if ((cnt_ff == '0) && bsigned_ff) begin
               acc_in = acc_ff - mcand_ff;
            end else begin
               acc_in = acc_ff + mcand_ff;
            end
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      acc_ff     <= acc_in;
      cnt_ff     <= cnt_in;
      bsigned_ff <= bsigned_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

`default_nettype wire
